@@ rtl/hrlp_pkg.sv @@
`default_nettype none
package hrlp_pkg;

    // Character codes
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    // Byte roles
    localparam logic [2:0] ROLE_METHOD  = 3'd0;
    localparam logic [2:0] ROLE_SPACE   = 3'd1;
    localparam logic [2:0] ROLE_PATH    = 3'd2;
    localparam logic [2:0] ROLE_QMARK   = 3'd3;
    localparam logic [2:0] ROLE_QUERY   = 3'd4;
    localparam logic [2:0] ROLE_VERSION = 3'd5;
    localparam logic [2:0] ROLE_LF      = 3'd6;
    localparam logic [2:0] ROLE_SURPLUS = 3'd7;

    // Part indexes
    localparam logic [2:0] PART_METHOD  = 3'd0;
    localparam logic [2:0] PART_PATH    = 3'd1;
    localparam logic [2:0] PART_VERSION = 3'd2;
    localparam logic [2:0] PART_SURPLUS = 3'd3;
    localparam logic [2:0] PART_MAX     = 3'd7;

    // Method codes
    localparam logic [3:0] METHOD_UNKNOWN = 4'd0;
    localparam logic [3:0] METHOD_GET     = 4'd1;
    localparam logic [3:0] METHOD_POST    = 4'd2;
    localparam logic [3:0] METHOD_PUT     = 4'd3;
    localparam logic [3:0] METHOD_DELETE  = 4'd4;
    localparam logic [3:0] METHOD_PATCH   = 4'd5;
    localparam logic [3:0] METHOD_HEAD    = 4'd6;
    localparam logic [3:0] METHOD_OPTIONS = 4'd7;
    localparam logic [3:0] METHOD_CONNECT = 4'd8;
    localparam logic [3:0] METHOD_TRACE   = 4'd9;

    // Method names packed first byte lowest
    localparam logic [55:0] TEXT_GET     = 56'h544547;
    localparam logic [55:0] TEXT_POST    = 56'h54534F50;
    localparam logic [55:0] TEXT_PUT     = 56'h545550;
    localparam logic [55:0] TEXT_DELETE  = 56'h4554454C4544;
    localparam logic [55:0] TEXT_PATCH   = 56'h4843544150;
    localparam logic [55:0] TEXT_HEAD    = 56'h44414548;
    localparam logic [55:0] TEXT_OPTIONS = 56'h534E4F4954504F;
    localparam logic [55:0] TEXT_CONNECT = 56'h5443454E4E4F43;
    localparam logic [55:0] TEXT_TRACE   = 56'h4543415254;

    // "HTTP/" packed first byte lowest
    localparam logic [39:0] TEXT_PREFIX = 40'h2F50545448;

    // Error codes
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_PARTS   = 2'd1;
    localparam logic [1:0] ERR_METHOD  = 2'd2;
    localparam logic [1:0] ERR_VERSION = 2'd3;

    // Per-line tracking state
    typedef struct packed {
        logic [2:0]  part_index;
        logic [55:0] method_chars;
        logic [3:0]  method_length;
        logic        query_seen;
        logic [39:0] prefix_chars;
        logic [2:0]  prefix_length;
        logic        slash_seen;
        logic [23:0] version_chars;
        logic [2:0]  version_length;
    } hrlp_line_t;

    localparam hrlp_line_t LINE_RESET = '0;

    // Line summary reported on the line feed
    typedef struct packed {
        logic [3:0] method_code;
        logic [3:0] proto_major;
        logic [3:0] proto_minor;
        logic [1:0] error_code;
    } hrlp_summary_t;

    // Role of a byte given the state before it
    function automatic logic [2:0] role_of(hrlp_line_t s, logic [7:0] b);
        logic [2:0] r;
        if (s.part_index >= PART_SURPLUS) r = ROLE_SURPLUS;
        else if (b == CHAR_SPACE) r = ROLE_SPACE;
        else if (s.part_index == PART_METHOD) r = ROLE_METHOD;
        else if (s.part_index == PART_VERSION) r = ROLE_VERSION;
        else if (s.query_seen) r = ROLE_QUERY;
        else if (b == CHAR_QMARK) r = ROLE_QMARK;
        else r = ROLE_PATH;
        return r;
    endfunction

    // Fold one byte into the line state
    function automatic hrlp_line_t absorb_byte(hrlp_line_t s, logic [7:0] b);
        hrlp_line_t n;
        n = s;
        if (b == CHAR_SPACE) begin
            if (s.part_index != PART_MAX)
                n.part_index = s.part_index + 3'd1;
        end
        else if (s.part_index == PART_METHOD) begin
            for (int i = 0; i < 7; i++) begin
                if (s.method_length == 4'(i))
                    n.method_chars[8*i +: 8] = s.method_chars[8*i +: 8] | b;
            end
            if (s.method_length != 4'd8)
                n.method_length = s.method_length + 4'd1;
        end
        else if (s.part_index == PART_PATH) begin
            if (b == CHAR_QMARK)
                n.query_seen = 1'b1;
        end
        else if (s.part_index == PART_VERSION) begin
            if (!s.slash_seen) begin
                for (int i = 0; i < 5; i++) begin
                    if (s.prefix_length == 3'(i))
                        n.prefix_chars[8*i +: 8] = s.prefix_chars[8*i +: 8] | b;
                end
                if (s.prefix_length != 3'd7)
                    n.prefix_length = s.prefix_length + 3'd1;
                if (b == CHAR_SLASH)
                    n.slash_seen = 1'b1;
            end
            else begin
                for (int i = 0; i < 3; i++) begin
                    if (s.version_length == 3'(i))
                        n.version_chars[8*i +: 8] = s.version_chars[8*i +: 8] | b;
                end
                if (s.version_length != 3'd7)
                    n.version_length = s.version_length + 3'd1;
            end
        end
        return n;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage
`default_nettype wire

@@ rtl/hrlp_tracker.sv @@
`default_nettype none
module hrlp_tracker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step_en,
    input  wire logic [7:0]          data_byte,
    output hrlp_pkg::hrlp_line_t     line_state,
    output logic [2:0]               role
);
    import hrlp_pkg::*;

    hrlp_line_t line_reg;
    hrlp_line_t line_next;
    logic       last_cr_reg;
    logic       last_cr_next;
    hrlp_line_t with_cr;

    // Fold a held carriage return in first, then the new byte
    always_comb
    begin
        with_cr = last_cr_reg ? absorb_byte(line_reg, CHAR_CR) : line_reg;
        if (data_byte == CHAR_LF) begin
            line_next    = LINE_RESET;
            last_cr_next = 1'b0;
        end
        else if (data_byte == CHAR_CR) begin
            line_next    = with_cr;
            last_cr_next = 1'b1;
        end
        else begin
            line_next    = absorb_byte(with_cr, data_byte);
            last_cr_next = 1'b0;
        end
    end

    // Advance state on each processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_reg    <= LINE_RESET;
            last_cr_reg <= 1'b0;
        end
        else if (step_en) begin
            line_reg    <= line_next;
            last_cr_reg <= last_cr_next;
        end
    end

    assign line_state = line_reg;
    assign role       = (data_byte == CHAR_LF) ? ROLE_LF : role_of(line_reg, data_byte);

endmodule
`default_nettype wire

@@ rtl/hrlp_summary.sv @@
`default_nettype none
module hrlp_summary (
    input  wire hrlp_pkg::hrlp_line_t line_state,
    output hrlp_pkg::hrlp_summary_t   summary
);
    import hrlp_pkg::*;

    logic [3:0] code;
    logic       head_ok;
    logic       ver_ok;
    logic [3:0] major;
    logic [3:0] minor;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;

    // Match the method text against the known names
    always_comb
    begin
        code = METHOD_UNKNOWN;
        case (line_state.method_length)
            4'd3:
            begin
                if (line_state.method_chars == TEXT_GET) code = METHOD_GET;
                else if (line_state.method_chars == TEXT_PUT) code = METHOD_PUT;
            end
            4'd4:
            begin
                if (line_state.method_chars == TEXT_POST) code = METHOD_POST;
                else if (line_state.method_chars == TEXT_HEAD) code = METHOD_HEAD;
            end
            4'd5:
            begin
                if (line_state.method_chars == TEXT_PATCH) code = METHOD_PATCH;
                else if (line_state.method_chars == TEXT_TRACE) code = METHOD_TRACE;
            end
            4'd6:
            begin
                if (line_state.method_chars == TEXT_DELETE) code = METHOD_DELETE;
            end
            4'd7:
            begin
                if (line_state.method_chars == TEXT_OPTIONS) code = METHOD_OPTIONS;
                else if (line_state.method_chars == TEXT_CONNECT) code = METHOD_CONNECT;
            end
            default: code = METHOD_UNKNOWN;
        endcase
    end

    // Check "HTTP/" then one digit, or digit dot digit
    always_comb
    begin
        c0 = line_state.version_chars[7:0];
        c1 = line_state.version_chars[15:8];
        c2 = line_state.version_chars[23:16];
        head_ok = (line_state.part_index >= PART_VERSION) && line_state.slash_seen
                  && (line_state.prefix_length == 3'd5)
                  && (line_state.prefix_chars == TEXT_PREFIX);
        ver_ok = 1'b0;
        major  = 4'd0;
        minor  = 4'd0;
        if (head_ok && line_state.version_length == 3'd1 && is_digit(c0)) begin
            ver_ok = 1'b1;
            major  = c0[3:0];
        end
        else if (head_ok && line_state.version_length == 3'd3 && c1 == CHAR_DOT
                 && is_digit(c0) && is_digit(c2)) begin
            ver_ok = 1'b1;
            major  = c0[3:0];
            minor  = c2[3:0];
        end
    end

    // Lowest applicable error wins
    always_comb
    begin
        summary.method_code = code;
        summary.proto_major = major;
        summary.proto_minor = minor;
        if (line_state.part_index != PART_VERSION) summary.error_code = ERR_PARTS;
        else if (code == METHOD_UNKNOWN) summary.error_code = ERR_METHOD;
        else if (!ver_ok) summary.error_code = ERR_VERSION;
        else summary.error_code = ERR_OK;
    end

endmodule
`default_nettype wire

@@ rtl/http_request_line_parser_top.sv @@
// HTTP request line parser.
// Input channel: in_valid / in_ready carry one byte of the request line per
// beat on data_byte. Output channel: out_valid / out_ready carry one result
// per input beat: the byte itself (byte_out), its role, and on the line feed
// line_end = 1 with method_code, proto_major, proto_minor and error_code.
// Those four fields are zero whenever line_end is 0.
// A byte accepted from the input channel sits in the input register and
// moves into the output register once that register is free.
// Throughput: one byte per cycle while out_ready stays high; the per-line
// state update is combinational logic on registered state.
// The output register is refilled in the same cycle that its beat is taken,
// so the block keeps accepting while out_ready is high. When out_ready is
// low, one more byte is taken into the input register, then in_ready drops
// until the output drains.
// Reset (rst_n low, asynchronous) empties both registers and returns the line
// state to the start of a line. The line state also returns to its start
// after every line feed.
`default_nettype none
module http_request_line_parser_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      byte_out,
    output logic [2:0]      role,
    output logic            line_end,
    output logic [3:0]      method_code,
    output logic [3:0]      proto_major,
    output logic [3:0]      proto_minor,
    output logic [1:0]      error_code
);
    import hrlp_pkg::*;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic [7:0]    s1_byte_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    out_byte_reg;
    logic [2:0]    out_role_reg;
    logic          out_end_reg;
    hrlp_summary_t out_sum_reg;

    logic          out_free;
    logic          s1_adv;
    logic          in_take;
    hrlp_line_t    line_state;
    logic [2:0]    s1_role;
    hrlp_summary_t s1_sum;
    logic          s1_is_lf;

    // Handshake control
    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_take  = in_valid && in_ready;
    assign s1_is_lf = (s1_byte_reg == CHAR_LF);

    hrlp_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (s1_adv),
        .data_byte  (s1_byte_reg),
        .line_state (line_state),
        .role       (s1_role)
    );

    hrlp_summary u_summary (
        .line_state (line_state),
        .summary    (s1_sum)
    );

    // Next valid flags
    always_comb
    begin
        s1_valid_next  = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture input beat
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_byte_reg <= data_byte;
    end

    // Load result register; summary only on the line feed
    always_ff @(posedge clk)
    begin
        if (s1_adv) begin
            out_byte_reg <= s1_byte_reg;
            out_role_reg <= s1_role;
            out_end_reg  <= s1_is_lf;
            out_sum_reg  <= s1_is_lf ? s1_sum : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_out    = out_byte_reg;
    assign role        = out_role_reg;
    assign line_end    = out_end_reg;
    assign method_code = out_sum_reg.method_code;
    assign proto_major = out_sum_reg.proto_major;
    assign proto_minor = out_sum_reg.proto_minor;
    assign error_code  = out_sum_reg.error_code;

    // Line state restarts after a line feed is processed
    a_lf_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_is_lf |=> line_state.part_index == PART_METHOD
                               && line_state.method_length == 4'd0)
        else $error("line state not cleared after line feed");

    // Summary fields stay zero off the line feed
    a_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_end |-> method_code == METHOD_UNKNOWN
                                   && error_code == ERR_OK
                                   && proto_major == 4'd0 && proto_minor == 4'd0)
        else $error("summary fields nonzero without line end");

    // Line feed role and line_end agree
    a_lf_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (role == ROLE_LF) == line_end)
        else $error("line feed role and line end disagree");

    // Empty output means input is open
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule
`default_nettype wire

@@ bench/hrlp_line_checker.sv @@
`timescale 1ns / 100ps
module hrlp_line_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] byte_out,
    input  logic [2:0] role,
    input  logic       line_end,
    input  logic [3:0] method_code,
    input  logic [3:0] proto_major,
    input  logic [3:0] proto_minor,
    input  logic [1:0] error_code,
    output int         mismatches,
    output int         pending,
    output int         beats_checked,
    output int         lines_clean,
    output int         lines_flagged
);
    import hrlp_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] role;
        logic       line_end;
        logic [3:0] method;
        logic [3:0] major;
        logic [3:0] minor;
        logic [1:0] err;
    } byte_tag_t;

    byte_tag_t expected_tags[$];

    // Line state of the predictor
    logic [2:0]  cur_part;
    logic [55:0] meth_text;
    logic [3:0]  meth_len;
    logic        in_query;
    logic [39:0] ver_prefix;
    logic [2:0]  prefix_len;
    logic        past_slash;
    logic [23:0] ver_text;
    logic [2:0]  ver_len;
    logic        cr_held;

    task automatic clear_line();
        cur_part   = PART_METHOD;
        meth_text  = '0;
        meth_len   = '0;
        in_query   = 1'b0;
        ver_prefix = '0;
        prefix_len = '0;
        past_slash = 1'b0;
        ver_text   = '0;
        ver_len    = '0;
        cr_held    = 1'b0;
    endtask

    function automatic logic [55:0] method_text(input logic [3:0] code);
        case (code)
            METHOD_GET:     return TEXT_GET;
            METHOD_POST:    return TEXT_POST;
            METHOD_PUT:     return TEXT_PUT;
            METHOD_DELETE:  return TEXT_DELETE;
            METHOD_PATCH:   return TEXT_PATCH;
            METHOD_HEAD:    return TEXT_HEAD;
            METHOD_OPTIONS: return TEXT_OPTIONS;
            METHOD_CONNECT: return TEXT_CONNECT;
            METHOD_TRACE:   return TEXT_TRACE;
            default:        return '0;
        endcase
    endfunction

    // Number of characters in a packed name (zero bytes pad the top)
    function automatic logic [3:0] text_length(input logic [55:0] txt);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 7; i++)
        begin
            if (txt[8*i +: 8] != 8'h00)
                n = 4'(i + 1);
        end
        return n;
    endfunction

    function automatic logic [3:0] match_method();
        logic [3:0] code;
        for (int k = 1; k <= 9; k++)
        begin
            code = 4'(k);
            if (meth_len == text_length(method_text(code)) && meth_text == method_text(code))
                return code;
        end
        return METHOD_UNKNOWN;
    endfunction

    function automatic logic decimal_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    // Fold one byte into the line state
    task automatic fold_byte(input logic [7:0] b);
        if (b == CHAR_SPACE)
        begin
            if (cur_part != PART_MAX)
                cur_part = cur_part + 3'd1;
        end
        else if (cur_part == PART_METHOD)
        begin
            if (meth_len < 4'd7)
                meth_text[8*meth_len +: 8] = b;
            if (meth_len < 4'd8)
                meth_len = meth_len + 4'd1;
        end
        else if (cur_part == PART_PATH)
        begin
            if (b == CHAR_QMARK)
                in_query = 1'b1;
        end
        else if (cur_part == PART_VERSION)
        begin
            if (!past_slash)
            begin
                if (prefix_len < 3'd5)
                    ver_prefix[8*prefix_len +: 8] = b;
                if (prefix_len < 3'd7)
                    prefix_len = prefix_len + 3'd1;
                if (b == CHAR_SLASH)
                    past_slash = 1'b1;
            end
            else
            begin
                if (ver_len < 3'd3)
                    ver_text[8*ver_len +: 8] = b;
                if (ver_len < 3'd7)
                    ver_len = ver_len + 3'd1;
            end
        end
    endtask

    // Tag one accepted byte and, on the line feed, summarize the line
    task automatic tag_byte(input logic [7:0] b, output byte_tag_t t);
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       ver_ok;
        t = '0;
        t.data = b;
        if (b == CHAR_LF)
        begin
            c0 = ver_text[7:0];
            c1 = ver_text[15:8];
            c2 = ver_text[23:16];
            ver_ok = 1'b0;
            t.role = ROLE_LF;
            t.line_end = 1'b1;
            t.method = match_method();
            if (cur_part >= PART_VERSION && past_slash && prefix_len == 3'd5
                && ver_prefix == TEXT_PREFIX)
            begin
                if (ver_len == 3'd1 && decimal_digit(c0))
                begin
                    ver_ok = 1'b1;
                    t.major = 4'(c0 - CHAR_ZERO);
                end
                else if (ver_len == 3'd3 && c1 == CHAR_DOT && decimal_digit(c0)
                         && decimal_digit(c2))
                begin
                    ver_ok = 1'b1;
                    t.major = 4'(c0 - CHAR_ZERO);
                    t.minor = 4'(c2 - CHAR_ZERO);
                end
            end
            if (cur_part != PART_VERSION)
                t.err = ERR_PARTS;
            else if (t.method == METHOD_UNKNOWN)
                t.err = ERR_METHOD;
            else if (!ver_ok)
                t.err = ERR_VERSION;
            else
                t.err = ERR_OK;
            clear_line();
        end
        else
        begin
            // a held carriage return that no line feed follows joins its part
            if (cr_held)
            begin
                fold_byte(CHAR_CR);
                cr_held = 1'b0;
            end
            if (cur_part >= PART_SURPLUS)
                t.role = ROLE_SURPLUS;
            else if (b == CHAR_SPACE)
                t.role = ROLE_SPACE;
            else if (cur_part == PART_METHOD)
                t.role = ROLE_METHOD;
            else if (cur_part == PART_VERSION)
                t.role = ROLE_VERSION;
            else if (in_query)
                t.role = ROLE_QUERY;
            else if (b == CHAR_QMARK)
                t.role = ROLE_QMARK;
            else
                t.role = ROLE_PATH;
            if (b == CHAR_CR)
                cr_held = 1'b1;
            else
                fold_byte(b);
        end
    endtask

    initial
    begin
        clear_line();
        mismatches = 0;
        pending = 0;
        beats_checked = 0;
        lines_clean = 0;
        lines_flagged = 0;
    end

    // Check the output beat against the oldest tag, then predict the input beat
    always @(posedge clk or negedge rst_n)
    begin
        byte_tag_t want;
        byte_tag_t got;
        if (!rst_n)
        begin
            clear_line();
            expected_tags.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {byte_out, role, line_end, method_code, proto_major,
                       proto_minor, error_code};
                if (expected_tags.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR at %0t: unexpected result beat byte=%02h role=%0d",
                                 $time, byte_out, role);
                end
                else
                begin
                    want = expected_tags.pop_front();
                    beats_checked++;
                    if (want.line_end)
                    begin
                        if (want.err == ERR_OK)
                            lines_clean++;
                        else
                            lines_flagged++;
                    end
                    if (got.data !== want.data || got.role !== want.role
                        || got.line_end !== want.line_end || got.method !== want.method
                        || got.major !== want.major || got.minor !== want.minor
                        || got.err !== want.err)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("ERROR at %0t: expected byte=%02h role=%0d end=%0b",
                                     $time, want.data, want.role, want.line_end,
                                     " method=%0d ver=%0d.%0d err=%0d",
                                     want.method, want.major, want.minor, want.err);
                            $display("              got      byte=%02h role=%0d end=%0b",
                                     got.data, got.role, got.line_end,
                                     " method=%0d ver=%0d.%0d err=%0d",
                                     got.method, got.major, got.minor, got.err);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                tag_byte(data_byte, want);
                expected_tags.push_back(want);
            end
            pending = expected_tags.size();
        end
    end

endmodule

@@ bench/http_request_line_parser_top_tb.sv @@
`timescale 1ns / 100ps
module http_request_line_parser_top_tb;
    import hrlp_pkg::*;

    localparam int ITEM_TARGET = 2000;
    localparam int CALM_TAIL   = 200;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] byte_out;
    logic [2:0] role;
    logic       line_end;
    logic [3:0] method_code;
    logic [3:0] proto_major;
    logic [3:0] proto_minor;
    logic [1:0] error_code;

    int mismatches;
    int pending;
    int beats_checked;
    int lines_clean;
    int lines_flagged;

    int         bytes_sent;
    logic       calm;
    int         stall_left;
    logic [7:0] line_q[$];

    http_request_line_parser_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .byte_out(byte_out),
        .role(role),
        .line_end(line_end),
        .method_code(method_code),
        .proto_major(proto_major),
        .proto_minor(proto_minor),
        .error_code(error_code)
    );

    hrlp_line_checker u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .byte_out(byte_out),
        .role(role),
        .line_end(line_end),
        .method_code(method_code),
        .proto_major(proto_major),
        .proto_minor(proto_minor),
        .error_code(error_code),
        .mismatches(mismatches),
        .pending(pending),
        .beats_checked(beats_checked),
        .lines_clean(lines_clean),
        .lines_flagged(lines_flagged)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stall the result side in short bursts, never in the calm tail
    always @(negedge clk)
    begin
        if (calm)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 5) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic string verb(input int k);
        case (k)
            0: return "GET";
            1: return "POST";
            2: return "PUT";
            3: return "DELETE";
            4: return "PATCH";
            5: return "HEAD";
            6: return "OPTIONS";
            7: return "CONNECT";
            default: return "TRACE";
        endcase
    endfunction

    // Mostly URL characters, with question marks and stray carriage returns
    function automatic logic [7:0] path_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
            return CHAR_QMARK;
        else if (r == 3)
            return CHAR_CR;
        else if (r == 4)
            return CHAR_SLASH;
        return 8'($urandom_range(8'h30, 8'h7A));
    endfunction

    // Characters around the digit range, to probe the digit bounds
    function automatic logic [7:0] near_digit();
        if ($urandom_range(0, 2) == 0)
            return 8'($urandom_range(8'h2D, 8'h3B));
        return 8'(CHAR_ZERO + $urandom_range(0, 9));
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(8'(s[i]));
    endtask

    // Hold a byte on the input until the block takes it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_byte(line_q[i]);
        line_q.delete();
    endtask

    // Build one line: mostly well formed, some broken, some pure noise
    task automatic build_line();
        int    n;
        int    form;
        string v;
        line_q.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 14);
            repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
            line_q.push_back(CHAR_LF);
            return;
        end

        // method
        if ($urandom_range(0, 7) != 0)
        begin
            push_text(verb($urandom_range(0, 8)));
            if ($urandom_range(0, 15) == 0)
                line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end
        else
        begin
            n = $urandom_range(0, 9);
            repeat (n) line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end
        line_q.push_back(CHAR_SPACE);

        // path and query
        line_q.push_back(CHAR_SLASH);
        n = $urandom_range(0, 8);
        repeat (n) line_q.push_back(path_char());
        if ($urandom_range(0, 15) == 0)
            line_q.push_back(CHAR_SPACE);
        line_q.push_back(CHAR_SPACE);

        // version
        form = $urandom_range(0, 9);
        if (form < 7)
        begin
            push_text("HTTP/");
            if (form < 4)
            begin
                line_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                line_q.push_back(CHAR_DOT);
                line_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
            end
            else if (form < 6)
                line_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
            else
            begin
                n = $urandom_range(0, 5);
                repeat (n) line_q.push_back(near_digit());
            end
        end
        else if (form == 7)
        begin
            push_text("HTTP/1.1");
            line_q[line_q.size() - 8 + $urandom_range(0, 4)] = 8'($urandom_range(8'h41, 8'h7A));
        end
        else if (form == 8)
        begin
            if ($urandom_range(0, 1) != 0)
                push_text("HTTPS/1.1");
            else
                push_text("HTTP1.1");
        end
        else
        begin
            push_text("HTTP/");
            line_q.push_back(near_digit());
            line_q.push_back(near_digit());
            line_q.push_back(near_digit());
        end

        // surplus parts
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                line_q.push_back(CHAR_SPACE);
                line_q.push_back(path_char());
            end
        end

        if ($urandom_range(0, 3) != 0)
            line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_LF);

        // spoil one byte now and then
        if ($urandom_range(0, 19) == 0)
            line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
    endtask

    initial
    begin
        #400_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        out_ready = 1'b0;
        calm = 1'b0;
        stall_left = 0;
        bytes_sent = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // clean line with a query, a later question mark and CR LF
        push_text("GET /?a? HTTP/1.1");
        line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_LF);
        send_line();
        // empty parts, a lone carriage return, surplus bytes, byte extremes
        line_q.push_back(CHAR_SPACE);
        line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_SPACE);
        line_q.push_back(CHAR_SPACE);
        line_q.push_back(8'hFF);
        line_q.push_back(8'h00);
        line_q.push_back(CHAR_LF);
        send_line();

        // random lines; drop all idling for the tail
        while (bytes_sent < ITEM_TARGET)
        begin
            build_line();
            if (bytes_sent >= ITEM_TARGET - CALM_TAIL)
                calm = 1'b1;
            send_line();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("Sent %0d request-line bytes, checked %0d result beats.",
                 bytes_sent, beats_checked);
        $display("Lines closed: %0d parsed clean, %0d flagged with an error code.",
                 lines_clean, lines_flagged);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/hrlp_pkg.sv
rtl/hrlp_tracker.sv
rtl/hrlp_summary.sv
rtl/http_request_line_parser_top.sv
bench/hrlp_line_checker.sv
bench/http_request_line_parser_top_tb.sv
